// ===== sv/bdlp_pkg.sv =====
// Package for the button debounce and long-press unit.
// Holds payload structs, opcode and register-index enums and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package bdlp_pkg;

  // Default sizing handed to the top-level parameters
  localparam int BUTTON_COUNT_DEF = 2;
  localparam int STAMP_BITS_DEF   = 32;

  // Field widths of the item payloads and the config port
  localparam int NOW_W    = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd25;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd225;

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_INIT   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_e;

  // One poll
  typedef struct packed {
    op_e              operation;
    logic [NOW_W-1:0] now_ms;
    logic             left_pin_level;
    logic             right_pin_level;
  } in_item_t;

  // One result
  typedef struct packed {
    logic left_held;
    logic left_press_event;
    logic left_release_event;
    logic left_click_event;
    logic left_long_event;
    logic right_held;
    logic right_press_event;
    logic right_release_event;
    logic right_click_event;
    logic right_long_event;
  } out_item_t;

endpackage

// ===== sv/bdlp_in_if.sv =====
// Input channel of the button debounce unit: valid/ready plus one poll item.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

interface bdlp_in_if;
  logic               valid;
  logic               ready;
  bdlp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/bdlp_out_if.sv =====
// Result channel of the button debounce unit: valid/ready plus one result item.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

interface bdlp_out_if;
  logic                valid;
  logic                ready;
  bdlp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/button_debounce_long_press_unit.sv =====
// Button debounce and long-press unit: two active-low buttons qualified per poll item.
// Polls come in on a valid/ready channel, one result item goes out per poll.
// Each poll passes an input register, then compare logic against the per-button
// state into the result register: one item per clock while the result side does
// not stall. The per-button state update is a wrapped subtract and compare on
// the STAMP_BITS-wide stamps. An initialize poll loads the levels from the pins
// and reports no events; an update poll debounces, then flags press, release,
// click (release with no long press) and a single long press. Intervals are to
// be written on the config port only while the unit is idle; the unit itself
// does not enforce this. Reset values are 25 ms and 225 ms.
// Depends on bdlp_pkg, bdlp_in_if, bdlp_out_if.
`timescale 1ns / 1ps

module button_debounce_long_press_unit #(
  parameter int BUTTON_COUNT = bdlp_pkg::BUTTON_COUNT_DEF,
  parameter int STAMP_BITS   = bdlp_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bdlp_in_if.sink                       in_if,
  bdlp_out_if.source                    out_if,
  input  logic                          cfg_we_i,
  input  bdlp_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [bdlp_pkg::CFG_W-1:0]    cfg_wdata_i
);

  typedef logic [STAMP_BITS-1:0] stamp_t;

  // Config registers
  logic [bdlp_pkg::CFG_W-1:0] deb_q, lp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= bdlp_pkg::DEBOUNCE_RST;
      lp_q  <= bdlp_pkg::LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bdlp_pkg::CFG_DEBOUNCE:   deb_q <= cfg_wdata_i;
        bdlp_pkg::CFG_LONG_PRESS: lp_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: input register feeds the result register
  logic               in_vld_q;
  bdlp_pkg::in_item_t in_q;
  logic               out_vld_q;
  bdlp_pkg::out_item_t out_q;
  logic               adv;

  assign adv         = !out_vld_q || out_if.ready;
  assign in_if.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_q <= in_if.data;
    end
  end

  logic   commit;
  logic   init;
  stamp_t now_s, deb_s, lp_s;

  assign commit = in_vld_q && adv;
  assign init   = (in_q.operation == bdlp_pkg::OP_INIT);
  assign now_s  = STAMP_BITS'(in_q.now_ms);
  assign deb_s  = STAMP_BITS'(deb_q);
  assign lp_s   = STAMP_BITS'(lp_q);

  // Per-button results
  logic [BUTTON_COUNT-1:0] held, ev_press, ev_rel, ev_click, ev_long;

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_btn
    logic   raw;
    logic   stable_q, last_q, long_q;
    stamp_t rc_q, ps_q;
    logic   stable_d, long_d, long_mid, take;
    stamp_t rc_d, ps_d;

    // Pins are active low; buttons without a pin read released
    if (i == 0) begin : g_left
      assign raw = ~in_q.left_pin_level;
    end else if (i == 1) begin : g_right
      assign raw = ~in_q.right_pin_level;
    end else begin : g_none
      assign raw = 1'b0;
    end

    // Debounce and long-press qualification
    always_comb begin
      rc_d     = (init || (raw != last_q)) ? now_s : rc_q;
      take     = !init && ((now_s - rc_d) >= deb_s) && (raw != stable_q);
      stable_d = (init || take) ? raw : stable_q;
      ev_press[i] = take && raw;
      ev_rel[i]   = take && !raw;
      ev_click[i] = take && !raw && !long_q;
      ps_d     = (init || (take && raw)) ? now_s : ps_q;
      long_mid = (init || take) ? 1'b0 : long_q;
      ev_long[i] = !init && stable_d && !long_mid && ((now_s - ps_d) >= lp_s);
      long_d   = long_mid || ev_long[i];
      held[i]  = stable_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stable_q <= 1'b0;
        last_q   <= 1'b0;
        long_q   <= 1'b0;
        rc_q     <= '0;
        ps_q     <= '0;
      end else if (commit) begin
        stable_q <= stable_d;
        last_q   <= raw;
        long_q   <= long_d;
        rc_q     <= rc_d;
        ps_q     <= ps_d;
      end
    end
  end

  // Result item assembly
  bdlp_pkg::out_item_t res;

  always_comb begin
    res = '0;
    res.left_held          = held[0];
    res.left_press_event   = ev_press[0];
    res.left_release_event = ev_rel[0];
    res.left_click_event   = ev_click[0];
    res.left_long_event    = ev_long[0];
  end

  bdlp_pkg::out_item_t res_full;

  if (BUTTON_COUNT > 1) begin : g_res_right
    always_comb begin
      res_full = res;
      res_full.right_held          = held[1];
      res_full.right_press_event   = ev_press[1];
      res_full.right_release_event = ev_rel[1];
      res_full.right_click_event   = ev_click[1];
      res_full.right_long_event    = ev_long[1];
    end
  end else begin : g_res_left_only
    assign res_full = res;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= res_full;
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  // A result never reports press and release of one button together
  a_press_rel_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.left_press_event && out_q.left_release_event) &&
                  !(out_q.right_press_event && out_q.right_release_event))
    else $error("press and release in one result");

  // A click only comes with a release
  a_click_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_q.left_click_event || out_q.left_release_event) &&
                  (!out_q.right_click_event || out_q.right_release_event))
    else $error("click without release");

  // A long press is only reported while the button is held
  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_q.left_long_event || out_q.left_held) &&
                  (!out_q.right_long_event || out_q.right_held))
    else $error("long press while released");

  // A committed poll shows up as a valid result in the next cycle
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_vld_q)
    else $error("committed poll lost");
`endif

endmodule

// ===== tb/sv/tb_button_debounce_long_press_unit.sv =====
// Self-checking testbench for button_debounce_long_press_unit: directed polls from a table,
// then random poll sequences under several interval settings, checked against a local predictor.
// Depends on bdlp_pkg, bdlp_in_if, bdlp_out_if and the unit itself.
`timescale 1ns / 1ps

module tb_button_debounce_long_press_unit;

  localparam int LIMIT_CYCLES = 500000;
  localparam int N_DIR        = 26;
  localparam int N_PHASE      = 6;
  localparam int PHASE_POLLS  = 250;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic      set_cfg;
    logic [15:0] deb_ms;
    logic [15:0] long_ms;
    bdlp_pkg::in_item_t  poll;
    logic      typed;
    bdlp_pkg::out_item_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // update before any initialize, idle then pressed pins
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0000, 1'b1, 1'b1}, 1'b1, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0019, 1'b0, 1'b0}, 1'b0, 10'b0},
    // initialize loads the pins, no events
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_INIT, 32'h0000_0064, 1'b0, 1'b1}, 1'b1,
      10'b10000_00000},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_INIT, 32'hFFFF_FFF0, 1'b1, 1'b1}, 1'b1, 10'b0},
    // left press across the stamp wrap, long press at exactly the interval
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'hFFFF_FFF5, 1'b0, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_000E, 1'b0, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_00EE, 1'b0, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_00EF, 1'b0, 1'b1}, 1'b0, 10'b0},
    // left release after long press: no click
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0300, 1'b1, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0318, 1'b1, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0319, 1'b1, 1'b1}, 1'b0, 10'b0},
    // right short press: click on release
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0400, 1'b1, 1'b0}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0419, 1'b1, 1'b0}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0420, 1'b1, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0439, 1'b1, 1'b1}, 1'b0, 10'b0},
    // left bounce that never settles
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0500, 1'b0, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0510, 1'b1, 1'b1}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, 10'b0},
    // zero intervals: press and long in one poll, release without click
    '{1'b1, 16'd0, 16'd0, '{bdlp_pkg::OP_INIT, 32'h1234_5678, 1'b1, 1'b1}, 1'b1, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h1234_5678, 1'b0, 1'b0}, 1'b1,
      10'b11001_11001},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h1234_5679, 1'b1, 1'b1}, 1'b1,
      10'b00100_00100},
    // largest intervals
    '{1'b1, 16'hFFFF, 16'hFFFF, '{bdlp_pkg::OP_INIT, 32'h0000_0000, 1'b1, 1'b1}, 1'b1, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0000_FFFF, 1'b0, 1'b0}, 1'b0, 10'b0},
    '{1'b0, 16'd0, 16'd0, '{bdlp_pkg::OP_UPDATE, 32'h0001_FFFE, 1'b0, 1'b0}, 1'b0, 10'b0}
  };

  string field_name [10] = '{"left_held", "left_press", "left_release", "left_click",
                             "left_long", "right_held", "right_press", "right_release",
                             "right_click", "right_long"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  bdlp_pkg::cfg_idx_e cfg_idx_i;
  logic [bdlp_pkg::CFG_W-1:0] cfg_wdata_i;

  bdlp_in_if  in_ch ();
  bdlp_out_if out_ch ();

  button_debounce_long_press_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: intervals and per-button debounce state
  logic [15:0] debounce_ms = bdlp_pkg::DEBOUNCE_RST;
  logic [15:0] long_ms     = bdlp_pkg::LONG_PRESS_RST;
  logic        btn_stable    [2] = '{1'b0, 1'b0};
  logic        btn_raw       [2] = '{1'b0, 1'b0};
  logic        btn_long_done [2] = '{1'b0, 1'b0};
  logic [31:0] btn_edge_ms   [2] = '{32'd0, 32'd0};
  logic [31:0] btn_press_ms  [2] = '{32'd0, 32'd0};

  bdlp_pkg::out_item_t pending_results [$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  bit quiet_tail    = 1'b0;
  bit long_hold_done = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Qualify one poll: updates the predictor state, returns the expected result
  function automatic bdlp_pkg::out_item_t qualify_poll(bdlp_pkg::in_item_t p);
    logic [4:0]  ev [2];
    logic        raw, press, rel, click, lng;
    logic [31:0] age;
    for (int i = 0; i < 2; i++) begin
      raw = (i == 0) ? ~p.left_pin_level : ~p.right_pin_level;
      press = 1'b0;
      rel   = 1'b0;
      click = 1'b0;
      lng   = 1'b0;
      if (p.operation == bdlp_pkg::OP_INIT) begin
        btn_stable[i]    = raw;
        btn_raw[i]       = raw;
        btn_edge_ms[i]   = p.now_ms;
        btn_press_ms[i]  = p.now_ms;
        btn_long_done[i] = 1'b0;
      end else begin
        if (raw != btn_raw[i]) begin
          btn_raw[i]     = raw;
          btn_edge_ms[i] = p.now_ms;
        end
        age = p.now_ms - btn_edge_ms[i];
        if (age >= 32'(debounce_ms) && raw != btn_stable[i]) begin
          btn_stable[i] = raw;
          if (raw) begin
            press            = 1'b1;
            btn_press_ms[i]  = p.now_ms;
            btn_long_done[i] = 1'b0;
          end else begin
            rel              = 1'b1;
            click            = ~btn_long_done[i];
            btn_long_done[i] = 1'b0;
          end
        end
        age = p.now_ms - btn_press_ms[i];
        if (btn_stable[i] && !btn_long_done[i] && age >= 32'(long_ms)) begin
          btn_long_done[i] = 1'b1;
          lng              = 1'b1;
        end
      end
      ev[i] = {btn_stable[i], press, rel, click, lng};
    end
    return {ev[0], ev[1]};
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // Offer one poll, wait for it to be taken, queue its expected result
  task automatic send_poll(bdlp_pkg::in_item_t p, logic typed, bdlp_pkg::out_item_t want);
    bdlp_pkg::out_item_t calc;
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    do @(posedge clk_i); while (!in_ch.ready);
    calc = qualify_poll(p);
    pending_results.push_back(typed ? want : calc);
    if (!quiet_tail && $urandom_range(0, 15) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Let every result come out, then let the pipeline settle
  task automatic drain_unit();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both interval registers on back-to-back cycles
  task automatic load_intervals(logic [15:0] deb, logic [15:0] lng);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bdlp_pkg::CFG_DEBOUNCE;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    debounce_ms = deb;
    cfg_idx_i   <= bdlp_pkg::CFG_LONG_PRESS;
    cfg_wdata_i <= lng;
    @(posedge clk_i);
    long_ms = lng;
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus: directed table, then random phases
  initial begin : stimulus
    int unsigned deb, lng, dt;
    int          sel;
    logic [31:0] clock_ms;
    logic        pin_l, pin_r;
    bdlp_pkg::in_item_t p;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = bdlp_pkg::CFG_DEBOUNCE;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < N_DIR; k++) begin
      if (DIR_ROWS[k].set_cfg) begin
        drain_unit();
        load_intervals(DIR_ROWS[k].deb_ms, DIR_ROWS[k].long_ms);
      end
      send_poll(DIR_ROWS[k].poll, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      case (ph)
        0: begin deb = 10;    lng = 60;    end
        1: begin deb = 0;     lng = 0;     end
        2: begin deb = 65535; lng = 65535; end
        3: begin deb = 1;     lng = 3;     end
        4: begin deb = $urandom_range(0, 65535); lng = $urandom_range(0, 65535); end
        default: begin deb = 25; lng = 225; end
      endcase
      drain_unit();
      load_intervals(deb[15:0], lng[15:0]);
      clock_ms = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_F000;
      pin_l = 1'b1;
      pin_r = 1'b1;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        if (ph == N_PHASE - 1 && n >= PHASE_POLLS - 100) quiet_tail = 1'b1;
        // time step chosen around the interval boundaries
        case ($urandom_range(0, 7))
          0: dt = 0;
          1: dt = $urandom_range(1, 4);
          2: dt = deb;
          3: dt = (deb > 0) ? deb - 1 : 0;
          4: dt = $urandom_range(0, deb + 2);
          5: dt = $urandom_range(0, lng / 4 + 1);
          6: dt = lng;
          default: dt = $urandom_range(0, 2 * (deb + lng) + 1);
        endcase
        clock_ms += dt;
        if ($urandom_range(0, 3) == 0) pin_l = ~pin_l;
        if ($urandom_range(0, 3) == 0) pin_r = ~pin_r;
        sel = $urandom_range(0, 31);
        p.operation       = (sel == 0) ? bdlp_pkg::OP_INIT : bdlp_pkg::OP_UPDATE;
        p.now_ms          = clock_ms;
        p.left_pin_level  = pin_l;
        p.right_pin_level = pin_r;
        // occasional noise: arbitrary stamp, pins and operation
        if (sel == 1) begin
          p.operation       = ($urandom_range(0, 1) == 0) ? bdlp_pkg::OP_INIT
                                                          : bdlp_pkg::OP_UPDATE;
          p.now_ms          = $urandom;
          p.left_pin_level  = 1'($urandom_range(0, 1));
          p.right_pin_level = 1'($urandom_range(0, 1));
        end
        send_poll(p, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_button_debounce_long_press_unit OK");
    end else begin
      $display("tb_button_debounce_long_press_unit NOT OK");
    end
    $finish;
  end

  // Result side ready: random stalls, one long hold-off to back the unit up
  initial begin : result_sink
    int unsigned hold;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk_i);
          hold++;
        end
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result taken with the oldest expectation
  always @(posedge clk_i) begin : result_check
    bdlp_pkg::out_item_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        for (int b = $bits(bdlp_pkg::out_item_t) - 1; b >= 0; b--) begin
          if (got[b] !== want[b]) begin
            report_mismatch($sformatf("result %0d %s got %b want %b", results_seen,
                                      field_name[$bits(bdlp_pkg::out_item_t) - 1 - b],
                                      got[b], want[b]));
          end
        end
      end
      results_seen++;
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_button_debounce_long_press_unit NOT OK");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
sv/bdlp_pkg.sv
sv/bdlp_in_if.sv
sv/bdlp_out_if.sv
sv/button_debounce_long_press_unit.sv
tb/sv/tb_button_debounce_long_press_unit.sv
